[rtl/ldc_pkg.sv]
package ldc_pkg;

    // fixed-point formats
    localparam int COORD_FRAC = 16;
    localparam int COEF_FRAC  = 48;
    localparam int NORM_SHIFT = 12;

    // centred coordinate, normalised coordinate and its square
    localparam int U_W  = 33;
    localparam int UN_W = U_W - NORM_SHIFT;
    localparam int SQ_W = 2 * UN_W;

    // register stages between the input beat and the result buffer
    localparam int NUM_STAGES = 23;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // range of a normalised offset that survives the scale back up
    localparam logic signed [63:0] DN_HI = 64'sd2147483647 >>> NORM_SHIFT;
    localparam logic signed [63:0] DN_LO = -(64'sd1 <<< (31 - NORM_SHIFT));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRINCIPAL_X   = 3'd0,
        CFG_PRINCIPAL_Y   = 3'd1,
        CFG_RADIAL_K1     = 3'd2,
        CFG_RADIAL_K2     = 3'd3,
        CFG_RADIAL_K3     = 3'd4,
        CFG_TANGENTIAL_P1 = 3'd5,
        CFG_TANGENTIAL_P2 = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [31:0] principal_x;
        logic [31:0] principal_y;
        logic [63:0] radial_k1;
        logic [63:0] radial_k2;
        logic [63:0] radial_k3;
        logic [63:0] tangential_p1;
        logic [63:0] tangential_p2;
    } cfg_regs_t;

    // 64-bit value with its saturation flag
    typedef struct packed {
        logic        clip;
        logic [63:0] val;
    } sat64_t;

    typedef struct packed {
        logic [31:0] offset_x;
        logic [31:0] offset_y;
        logic [31:0] corrected_x;
        logic [31:0] corrected_y;
        logic        clipped;
    } result_t;

    // clamp a 128-bit signed value to 64 bits
    function automatic sat64_t sat128(input logic signed [127:0] a);
        sat64_t r;
        if ((&a[127:63]) || (~|a[127:63])) begin
            r.clip = 1'b0;
            r.val  = a[63:0];
        end else begin
            r.clip = 1'b1;
            r.val  = a[127] ? S64_MIN : S64_MAX;
        end
        return r;
    endfunction

    // saturating 64-bit add
    function automatic sat64_t sadd64(input logic signed [63:0] a,
                                      input logic signed [63:0] b);
        logic signed [64:0] s;
        sat64_t r;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            r.clip = 1'b1;
            r.val  = s[64] ? S64_MIN : S64_MAX;
        end else begin
            r.clip = 1'b0;
            r.val  = s[63:0];
        end
        return r;
    endfunction

endpackage

[rtl/ldc_cfg_regs.sv]
module ldc_cfg_regs
    import ldc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_regs_t             regs
);

    cfg_regs_t regs_reg;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    // register decode, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PRINCIPAL_X:   regs_reg.principal_x   <= cfg_data[31:0];
                CFG_PRINCIPAL_Y:   regs_reg.principal_y   <= cfg_data[31:0];
                CFG_RADIAL_K1:     regs_reg.radial_k1     <= cfg_data;
                CFG_RADIAL_K2:     regs_reg.radial_k2     <= cfg_data;
                CFG_RADIAL_K3:     regs_reg.radial_k3     <= cfg_data;
                CFG_TANGENTIAL_P1: regs_reg.tangential_p1 <= cfg_data;
                CFG_TANGENTIAL_P2: regs_reg.tangential_p2 <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/ldc_mul.sv]
module ldc_mul
    import ldc_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic               use_coef,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output sat64_t             res
);

    logic [31:0]         al;
    logic [31:0]         bl;
    logic signed [31:0]  ah;
    logic signed [31:0]  bh;
    logic [63:0]         p00_next;
    logic signed [64:0]  p01_next;
    logic signed [64:0]  p10_next;
    logic signed [63:0]  p11_next;
    logic [63:0]         p00_reg;
    logic signed [64:0]  p01_reg;
    logic signed [64:0]  p10_reg;
    logic signed [63:0]  p11_reg;
    logic [63:0]         p00_b_reg;
    logic signed [63:0]  p11_b_reg;
    logic signed [65:0]  mid_reg;
    logic signed [127:0] prod_reg;
    logic signed [127:0] shifted;
    sat64_t              res_reg;

    // split into 32-bit halves, low halves unsigned
    assign al = a[31:0];
    assign bl = b[31:0];
    assign ah = a[63:32];
    assign bh = b[63:32];

    // partial products
    always_comb begin
        p00_next = {32'd0, al} * {32'd0, bl};
        p01_next = 65'(ah) * 65'($signed({1'b0, bl}));
        p10_next = 65'(bh) * 65'($signed({1'b0, al}));
        p11_next = 64'(ah) * 64'(bh);
    end

    // arithmetic shift back to the operand format
    assign shifted = use_coef ? (prod_reg >>> COEF_FRAC) : (prod_reg >>> COORD_FRAC);

    // four stages: partial products, middle sum, full product, shift and clamp
    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg   <= p00_next;
            p01_reg   <= p01_next;
            p10_reg   <= p10_next;
            p11_reg   <= p11_next;
            mid_reg   <= 66'(p01_reg) + 66'(p10_reg);
            p00_b_reg <= p00_reg;
            p11_b_reg <= p11_reg;
            prod_reg  <= $signed({p11_b_reg, p00_b_reg}) + (128'(mid_reg) <<< 32);
            res_reg   <= sat128(shifted);
        end
    end

    assign res = res_reg;

endmodule

[rtl/ldc_out_buf.sv]
module ldc_out_buf
    import ldc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    in_take;

    // the pipe moves whenever the skid slot is free
    assign in_ready  = !skid_valid_reg;
    assign in_take   = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // control: output register plus one skid slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (in_take) begin
            if (!out_valid_reg || out_ready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (out_valid_reg && out_ready) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_take) begin
            if (!out_valid_reg || out_ready) begin
                out_data_reg <= in_data;
            end else begin
                skid_data_reg <= in_data;
            end
        end else if (out_valid_reg && out_ready && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end
    end

    // skid slot only fills behind a held result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot full with output register empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid slot filled while output was free");

endmodule

[rtl/lens_distortion_correction_core.sv]
// Brown-Conrady lens distortion correction. Each input beat carries one image
// point in signed Q15.16; the core centres it on the principal point, forms
// r squared without a square root, applies the radial (k1, k2, k3) and
// decentering (p1, p2) terms and returns dx, dy, the corrected centred point
// and a flag that is set when any intermediate or final value saturated.
// A new point is taken on every clock unless the pipeline stalls; results come
// from the 64x64 multiplier chain r2 -> r4 -> r6 -> k3*r6 -> un*rad plus the
// centring, summing and clamping stages. A result held at the output is backed
// by a one-entry skid buffer, so the pipeline stalls only when both are full.
// Coefficients and the principal point (cfg index 0 to 6: principal_x,
// principal_y, k1, k2, k3, p1, p2; all reset to zero) are written through the
// cfg port; the user must do so only while no point is in flight, unenforced.
module lens_distortion_correction_core
    import ldc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_img_x,
    input  logic signed [31:0]    s_img_y,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_offset_x,
    output logic signed [31:0]    m_offset_y,
    output logic signed [31:0]    m_corrected_x,
    output logic signed [31:0]    m_corrected_y,
    output logic                  m_clipped
);

    cfg_regs_t cfg;
    logic      pipe_en;
    result_t   res_in;
    result_t   res_out;

    logic [NUM_STAGES:1] vld_reg;
    logic [NUM_STAGES:1] clip_reg;
    logic [NUM_STAGES:1] clip_add;

    logic signed [U_W-1:0]  u_pipe [1:22];
    logic signed [U_W-1:0]  v_pipe [1:22];
    logic signed [UN_W-1:0] un1;
    logic signed [UN_W-1:0] vn1;
    logic signed [UN_W-1:0] un16;
    logic signed [UN_W-1:0] vn16;
    logic signed [SQ_W-1:0] pxx_reg;
    logic signed [SQ_W-1:0] pyy_reg;
    logic signed [SQ_W-1:0] pxy_reg;
    logic signed [63:0]     r2_pipe [3:7];
    logic signed [63:0]     sxx_reg;
    logic signed [63:0]     syy_reg;
    logic signed [63:0]     sxy_reg;
    logic signed [63:0]     dsqx_reg;
    logic signed [63:0]     dsqy_reg;
    logic signed [63:0]     t2_pipe [4:5];
    logic signed [63:0]     t1x_reg;
    logic signed [63:0]     t1y_reg;
    logic signed [63:0]     tangx_pipe [10:20];
    logic signed [63:0]     tangy_pipe [10:20];
    logic signed [63:0]     k1r2_pipe [8:11];
    logic signed [63:0]     ab_pipe [12:15];
    logic signed [63:0]     rad_reg;
    logic signed [63:0]     dxn_reg;
    logic signed [63:0]     dyn_reg;
    logic signed [31:0]     dx_reg;
    logic signed [31:0]     dy_reg;
    logic signed [31:0]     offx_reg;
    logic signed [31:0]     offy_reg;
    logic signed [31:0]     cx_reg;
    logic signed [31:0]     cy_reg;

    logic signed [SQ_W-1:0] pxx_next;
    logic signed [SQ_W-1:0] pyy_next;
    logic signed [SQ_W-1:0] pxy_next;
    sat64_t r2_s, sxx_s, syy_s, sxy_s;
    sat64_t dsqx_s, dsqy_s, t2_s, t1x_s, t1y_s;
    sat64_t tangx_s, tangy_s, ab_s, rad_s, dxn_s, dyn_s;
    sat64_t m_r4, m_k1, m_r6, m_k2, m_k3;
    sat64_t m_tx1, m_tx2, m_ty1, m_ty2, m_ux, m_vy;
    logic signed [31:0] dx_next;
    logic signed [31:0] dy_next;
    logic               dx_clip;
    logic               dy_clip;
    logic signed [33:0] cx_sum;
    logic signed [33:0] cy_sum;
    logic signed [31:0] cx_next;
    logic signed [31:0] cy_next;
    logic               cx_clip;
    logic               cy_clip;

    // configuration registers
    ldc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    assign s_ready = pipe_en;

    // normalised coordinates
    assign un1  = UN_W'(u_pipe[1] >>> NORM_SHIFT);
    assign vn1  = UN_W'(v_pipe[1] >>> NORM_SHIFT);
    assign un16 = UN_W'(u_pipe[16] >>> NORM_SHIFT);
    assign vn16 = UN_W'(v_pipe[16] >>> NORM_SHIFT);

    // squares and cross product of the normalised point
    always_comb begin
        pxx_next = SQ_W'(un1) * SQ_W'(un1);
        pyy_next = SQ_W'(vn1) * SQ_W'(vn1);
        pxy_next = SQ_W'(un1) * SQ_W'(vn1);
    end

    // r squared and scaled squares, the decentering sums, the radial factor and the offsets
    always_comb begin
        r2_s    = sat128((128'(pxx_reg) + 128'(pyy_reg)) >>> COORD_FRAC);
        sxx_s   = sat128(128'(pxx_reg) >>> COORD_FRAC);
        syy_s   = sat128(128'(pyy_reg) >>> COORD_FRAC);
        sxy_s   = sat128(128'(pxy_reg) >>> COORD_FRAC);
        dsqx_s  = sadd64(sxx_reg, sxx_reg);
        dsqy_s  = sadd64(syy_reg, syy_reg);
        t2_s    = sadd64(sxy_reg, sxy_reg);
        t1x_s   = sadd64(r2_pipe[4], dsqx_reg);
        t1y_s   = sadd64(r2_pipe[4], dsqy_reg);
        tangx_s = sadd64(m_tx1.val, m_tx2.val);
        tangy_s = sadd64(m_ty1.val, m_ty2.val);
        ab_s    = sadd64(k1r2_pipe[11], m_k2.val);
        rad_s   = sadd64(ab_pipe[15], m_k3.val);
        dxn_s   = sadd64(m_ux.val, tangx_pipe[20]);
        dyn_s   = sadd64(m_vy.val, tangy_pipe[20]);
    end

    // scale the offsets back up to image units
    always_comb begin
        dx_clip = 1'b1;
        dy_clip = 1'b1;
        if (dxn_reg > DN_HI) begin
            dx_next = S32_MAX;
        end else if (dxn_reg < DN_LO) begin
            dx_next = S32_MIN;
        end else begin
            dx_next = 32'(dxn_reg <<< NORM_SHIFT);
            dx_clip = 1'b0;
        end
        if (dyn_reg > DN_HI) begin
            dy_next = S32_MAX;
        end else if (dyn_reg < DN_LO) begin
            dy_next = S32_MIN;
        end else begin
            dy_next = 32'(dyn_reg <<< NORM_SHIFT);
            dy_clip = 1'b0;
        end
    end

    // corrected centred point
    always_comb begin
        cx_sum  = 34'(u_pipe[22]) + 34'(dx_reg);
        cy_sum  = 34'(v_pipe[22]) + 34'(dy_reg);
        cx_clip = !((&cx_sum[33:31]) || (~|cx_sum[33:31]));
        cy_clip = !((&cy_sum[33:31]) || (~|cy_sum[33:31]));
        cx_next = cx_clip ? (cx_sum[33] ? S32_MIN : S32_MAX) : cx_sum[31:0];
        cy_next = cy_clip ? (cy_sum[33] ? S32_MIN : S32_MAX) : cy_sum[31:0];
    end

    // saturation flags joining the item at the stage where each arises
    always_comb begin
        clip_add     = '0;
        clip_add[3]  = r2_s.clip | sxx_s.clip | syy_s.clip | sxy_s.clip;
        clip_add[4]  = dsqx_s.clip | dsqy_s.clip | t2_s.clip;
        clip_add[5]  = t1x_s.clip | t1y_s.clip;
        clip_add[8]  = m_r4.clip | m_k1.clip;
        clip_add[10] = m_tx1.clip | m_tx2.clip | m_ty1.clip | m_ty2.clip
                     | tangx_s.clip | tangy_s.clip;
        clip_add[12] = m_r6.clip | m_k2.clip | ab_s.clip;
        clip_add[16] = m_k3.clip | rad_s.clip;
        clip_add[21] = m_ux.clip | m_vy.clip | dxn_s.clip | dyn_s.clip;
        clip_add[22] = dx_clip | dy_clip;
        clip_add[23] = cx_clip | cy_clip;
    end

    // powers of r squared
    ldc_mul u_mul_r4 (.aclk(aclk), .en(pipe_en), .use_coef(1'b0),
        .a(r2_pipe[3]), .b(r2_pipe[3]), .res(m_r4));
    ldc_mul u_mul_r6 (.aclk(aclk), .en(pipe_en), .use_coef(1'b0),
        .a(m_r4.val), .b(r2_pipe[7]), .res(m_r6));

    // radial terms
    ldc_mul u_mul_k1 (.aclk(aclk), .en(pipe_en), .use_coef(1'b1),
        .a(cfg.radial_k1), .b(r2_pipe[3]), .res(m_k1));
    ldc_mul u_mul_k2 (.aclk(aclk), .en(pipe_en), .use_coef(1'b1),
        .a(cfg.radial_k2), .b(m_r4.val), .res(m_k2));
    ldc_mul u_mul_k3 (.aclk(aclk), .en(pipe_en), .use_coef(1'b1),
        .a(cfg.radial_k3), .b(m_r6.val), .res(m_k3));

    // decentering terms
    ldc_mul u_mul_tx1 (.aclk(aclk), .en(pipe_en), .use_coef(1'b1),
        .a(cfg.tangential_p1), .b(t1x_reg), .res(m_tx1));
    ldc_mul u_mul_tx2 (.aclk(aclk), .en(pipe_en), .use_coef(1'b1),
        .a(cfg.tangential_p2), .b(t2_pipe[5]), .res(m_tx2));
    ldc_mul u_mul_ty1 (.aclk(aclk), .en(pipe_en), .use_coef(1'b1),
        .a(cfg.tangential_p2), .b(t1y_reg), .res(m_ty1));
    ldc_mul u_mul_ty2 (.aclk(aclk), .en(pipe_en), .use_coef(1'b1),
        .a(cfg.tangential_p1), .b(t2_pipe[5]), .res(m_ty2));

    // radial factor applied to the normalised point
    ldc_mul u_mul_ux (.aclk(aclk), .en(pipe_en), .use_coef(1'b0),
        .a(64'(un16)), .b(rad_reg), .res(m_ux));
    ldc_mul u_mul_vy (.aclk(aclk), .en(pipe_en), .use_coef(1'b0),
        .a(64'(vn16)), .b(rad_reg), .res(m_vy));

    // stage valid bits and saturation flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            clip_reg <= '0;
        end else if (pipe_en) begin
            vld_reg  <= {vld_reg[NUM_STAGES-1:1], s_valid};
            clip_reg <= {clip_reg[NUM_STAGES-1:1] | clip_add[NUM_STAGES:2], 1'b0};
        end
    end

    // datapath stages
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            u_pipe[1] <= U_W'(s_img_x) - U_W'($signed(cfg.principal_x));
            v_pipe[1] <= U_W'(s_img_y) - U_W'($signed(cfg.principal_y));
            for (int t = 2; t <= 22; t++) begin
                u_pipe[t] <= u_pipe[t-1];
                v_pipe[t] <= v_pipe[t-1];
            end
            pxx_reg <= pxx_next;
            pyy_reg <= pyy_next;
            pxy_reg <= pxy_next;
            r2_pipe[3] <= r2_s.val;
            for (int t = 4; t <= 7; t++) begin
                r2_pipe[t] <= r2_pipe[t-1];
            end
            sxx_reg    <= sxx_s.val;
            syy_reg    <= syy_s.val;
            sxy_reg    <= sxy_s.val;
            dsqx_reg   <= dsqx_s.val;
            dsqy_reg   <= dsqy_s.val;
            t2_pipe[4] <= t2_s.val;
            t2_pipe[5] <= t2_pipe[4];
            t1x_reg    <= t1x_s.val;
            t1y_reg    <= t1y_s.val;
            tangx_pipe[10] <= tangx_s.val;
            tangy_pipe[10] <= tangy_s.val;
            for (int t = 11; t <= 20; t++) begin
                tangx_pipe[t] <= tangx_pipe[t-1];
                tangy_pipe[t] <= tangy_pipe[t-1];
            end
            k1r2_pipe[8] <= m_k1.val;
            for (int t = 9; t <= 11; t++) begin
                k1r2_pipe[t] <= k1r2_pipe[t-1];
            end
            ab_pipe[12] <= ab_s.val;
            for (int t = 13; t <= 15; t++) begin
                ab_pipe[t] <= ab_pipe[t-1];
            end
            rad_reg  <= rad_s.val;
            dxn_reg  <= dxn_s.val;
            dyn_reg  <= dyn_s.val;
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            offx_reg <= dx_reg;
            offy_reg <= dy_reg;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
        end
    end

    // result beat into the output buffer
    always_comb begin
        res_in.offset_x    = offx_reg;
        res_in.offset_y    = offy_reg;
        res_in.corrected_x = cx_reg;
        res_in.corrected_y = cy_reg;
        res_in.clipped     = clip_reg[NUM_STAGES];
    end

    ldc_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_reg[NUM_STAGES]),
        .in_ready  (pipe_en),
        .in_data   (res_in),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res_out)
    );

    assign m_offset_x    = res_out.offset_x;
    assign m_offset_y    = res_out.offset_y;
    assign m_corrected_x = res_out.corrected_x;
    assign m_corrected_y = res_out.corrected_y;
    assign m_clipped     = res_out.clipped;

    // a stalled pipe keeps every item where it is
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(vld_reg))
        else $error("stage valid bits moved during a stall");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[1])
        else $error("accepted beat missing from first stage");

endmodule
